[rtl/dlpd_pkg.sv]
// Package for the lid and load presence detector.
// Beat payload types, status struct and fixed constants; no dependencies.
package dlpd_pkg;

   // Input beat payload
   typedef struct packed {
      logic [14:0]        echo_width_a;
      logic [14:0]        echo_width_b;
      logic [14:0]        echo_width_c;
      logic [14:0]        echo_width_d;
      logic [14:0]        echo_width_e;
      logic               load_ready;
      logic signed [23:0] load_reading;
      logic [31:0]        now_ms;
   } req_type;

   // Result beat payload
   typedef struct packed {
      logic [16:0] distance_avg_q8;
      logic        lid_open;
      logic        lid_changed;
      logic [1:0]  load_event;
   } rsp_type;

   // Averaging unit status back to the sequencer
   typedef struct packed {
      logic        done;
      logic [16:0] avg_q8;
   } avg_status_type;

   localparam int MaxEchoFields = 5;

   // echo width (us) * 17 = distance in units of 1/1000 cm
   localparam logic [18:0] EchoProdMin = 19'd500;
   localparam logic [18:0] EchoProdMax = 19'd400000;
   // floor(x / 1000) = (x * ceil(2^28 / 1000)) >> 28, exact for x < 400000
   localparam logic [18:0] DivRecip    = 19'd268436;
   localparam int          DivShift    = 28;

   // Register indexes
   localparam logic [1:0] CSR_OPEN_DISTANCE = 2'd0;
   localparam logic [1:0] CSR_OPEN_HOLD     = 2'd1;
   localparam logic [1:0] CSR_LOAD_THRESH   = 2'd2;
   localparam logic [1:0] CSR_DETECT_HOLD   = 2'd3;

   // Register reset values
   localparam logic [8:0]  OpenDistanceReset = 9'd6;
   localparam logic [15:0] OpenHoldReset     = 16'd1000;
   localparam logic [22:0] LoadThreshReset   = 23'd50;
   localparam logic [15:0] DetectHoldReset   = 16'd1000;

   // Load event codes
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_PLACED  = 2'd1;
   localparam logic [1:0] EVT_REMOVED = 2'd2;

endpackage

[rtl/dlpd_avg_unit.sv]
// Distance averaging unit: one echo sample per cycle through a shared
// multiplier, then a bit-serial divide by the valid count. Uses dlpd_pkg.
module dlpd_avg_unit
   import dlpd_pkg::*;
#(
   parameter int NUM_SAMPLES = 5
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [14:0]    echo_width [MaxEchoFields],
   input  logic [16:0]    last_distance_q8,
   output avg_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SAMPLE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;

   localparam logic [2:0] LastIdx = 3'(NUM_SAMPLES - 1);
   localparam logic [4:0] LastBit = 5'd18;

   logic [1:0]  state_ff, state_in;
   logic [2:0]  idx_ff, idx_in;
   logic [10:0] sum_ff, sum_in;
   logic [2:0]  count_ff, count_in;
   logic [18:0] dividend_ff, dividend_in;
   logic [18:0] quot_ff, quot_in;
   logic [2:0]  rem_ff, rem_in;
   logic [4:0]  bit_ff, bit_in;
   logic        done_ff, done_in;
   logic [16:0] avg_ff, avg_in;

   logic [14:0] t;
   logic [19:0] prod;
   logic [37:0] scaled;
   logic [8:0]  dist_cm;
   logic        sample_ok;
   logic [10:0] sum_next;
   logic [2:0]  count_next;
   logic [3:0]  trial;
   logic        fits;

   // widest 15-bit echo times 17 needs 20 bits
   assign t         = echo_width[idx_ff];
   assign prod      = {1'b0, t, 4'b0} + {5'b0, t};
   assign sample_ok = (prod > {1'b0, EchoProdMin}) && (prod < {1'b0, EchoProdMax});
   assign scaled    = {18'b0, prod} * {19'b0, DivRecip};
   assign dist_cm   = scaled[DivShift+8:DivShift];
   assign sum_next  = sample_ok ? (sum_ff + {2'b0, dist_cm}) : sum_ff;
   assign count_next = sample_ok ? (count_ff + 3'd1) : count_ff;

   assign trial = {rem_ff, dividend_ff[18]};
   assign fits  = trial >= {1'b0, count_ff};

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      dividend_in = dividend_ff;
      quot_in     = quot_ff;
      rem_in      = rem_ff;
      bit_in      = bit_ff;
      done_in     = 1'b0;
      avg_in      = avg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SAMPLE;
               idx_in   = 3'd0;
               sum_in   = 11'd0;
               count_in = 3'd0;
            end
         end
         ST_SAMPLE: begin
            sum_in   = sum_next;
            count_in = count_next;
            idx_in   = idx_ff + 3'd1;
            if (idx_ff == LastIdx) begin
               if (count_next == 3'd0) begin
                  // nothing valid: hold the previous average
                  state_in = ST_IDLE;
                  done_in  = 1'b1;
                  avg_in   = last_distance_q8;
               end else begin
                  state_in    = ST_DIVIDE;
                  dividend_in = {sum_next, 8'b0};
                  quot_in     = 19'd0;
                  rem_in      = 3'd0;
                  bit_in      = 5'd0;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in      = fits ? 3'(trial - {1'b0, count_ff}) : trial[2:0];
            quot_in     = {quot_ff[17:0], fits};
            dividend_in = {dividend_ff[17:0], 1'b0};
            bit_in      = bit_ff + 5'd1;
            if (bit_ff == LastBit) begin
               state_in = ST_IDLE;
               done_in  = 1'b1;
               avg_in   = quot_in[16:0];
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      idx_ff      <= idx_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      avg_ff      <= avg_in;
   end

   assign status.done   = done_ff;
   assign status.avg_q8 = avg_ff;

endmodule

[rtl/door_and_load_presence_detector_top.sv]
// Lid and load presence detector, top level. Uses dlpd_pkg, dlpd_avg_unit.
// Result path: the beat is captured, the start pulse is registered, the averaging unit
//   samples each echo field and runs the bit-serial divide, its done status is registered,
//   and the lid and load decision is registered into the result. A new beat is accepted
//   only after the previous result commits; no valid sample skips the divide. A held result stalls the input.
// Reset (synchronous): registers back to defaults, lid closed, timers idle.
module door_and_load_presence_detector_top
   import dlpd_pkg::*;
#(
   parameter int ECHO_SAMPLES = 5
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   // result beats
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_data
);

   // only five echo fields exist on the beat
   localparam int NumSamples = (ECHO_SAMPLES > MaxEchoFields) ? MaxEchoFields : ECHO_SAMPLES;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WAIT   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // control registers
   logic [8:0]  open_distance_ff;
   logic [15:0] open_hold_ff;
   logic [22:0] load_thresh_ff;
   logic [15:0] detect_hold_ff;

   // sequencer and captured beat
   logic [1:0]  state_ff, state_in;
   req_type     req_ff;
   logic [16:0] avg_ff;
   logic        req_fire;
   logic        out_free;
   logic        commit;

   // detector state
   logic               lid_open_ff, lid_open_in;
   logic               open_run_ff, open_run_in;
   logic [31:0]        open_start_ff, open_start_in;
   logic signed [23:0] baseline_ff, baseline_in;
   logic               det_run_ff, det_run_in;
   logic [31:0]        det_start_ff, det_start_in;
   logic               present_ff, present_in;
   logic [16:0]        last_dist_ff;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [14:0]    echo_width [MaxEchoFields];
   avg_status_type avg_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_FINISH) && out_free;

   assign echo_width[0] = req_ff.echo_width_a;
   assign echo_width[1] = req_ff.echo_width_b;
   assign echo_width[2] = req_ff.echo_width_c;
   assign echo_width[3] = req_ff.echo_width_d;
   assign echo_width[4] = req_ff.echo_width_e;

   // start pulse in the cycle after capture so the unit sees the new beat
   logic req_fire_d;
   always_ff @(posedge clock) begin
      if (reset) begin
         req_fire_d <= 1'b0;
      end else begin
         req_fire_d <= req_fire;
      end
   end

   // Sample loop and divide run in the averaging unit
   dlpd_avg_unit #(
      .NUM_SAMPLES (NumSamples)
   ) u_avg (
      .clock            (clock),
      .reset            (reset),
      .start            (req_fire_d),
      .echo_width       (echo_width),
      .last_distance_q8 (last_dist_ff),
      .status           (avg_status)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = ST_WAIT;
         ST_WAIT:   if (avg_status.done) state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Lid and load decision, evaluated in the finish cycle
   logic        dist_high;
   logic [31:0] open_ref, open_elapsed;
   logic        new_open, changed, opening;
   logic        det_run_cur, present_cur;
   logic signed [23:0] base_cur;
   logic signed [24:0] load_diff;
   logic        above;
   logic [31:0] det_ref, det_elapsed;
   logic [1:0]  event_code;

   always_comb begin
      dist_high    = avg_ff >= {open_distance_ff, 8'b0};
      open_ref     = open_run_ff ? open_start_ff : req_ff.now_ms;
      open_elapsed = req_ff.now_ms - open_ref;
      new_open     = dist_high && ((open_elapsed >= {16'b0, open_hold_ff}) || lid_open_ff);
      changed      = new_open != lid_open_ff;
      opening      = changed && new_open;

      open_run_in   = dist_high;
      open_start_in = dist_high ? open_ref : open_start_ff;
      lid_open_in   = new_open;

      // opening takes a fresh baseline and clears the load tracker
      base_cur    = opening ? req_ff.load_reading : baseline_ff;
      det_run_cur = opening ? 1'b0 : det_run_ff;
      present_cur = opening ? 1'b0 : present_ff;
      baseline_in = base_cur;

      load_diff   = $signed({req_ff.load_reading[23], req_ff.load_reading})
                    - $signed({base_cur[23], base_cur});
      above       = load_diff > $signed({2'b0, load_thresh_ff});
      det_ref     = det_run_cur ? det_start_ff : req_ff.now_ms;
      det_elapsed = req_ff.now_ms - det_ref;

      det_run_in   = det_run_cur;
      det_start_in = det_start_ff;
      present_in   = present_cur;
      event_code   = EVT_NONE;
      if (new_open && req_ff.load_ready) begin
         if (above) begin
            det_run_in   = 1'b1;
            det_start_in = det_ref;
            if ((det_elapsed >= {16'b0, detect_hold_ff}) && !present_cur) begin
               present_in = 1'b1;
               event_code = EVT_PLACED;
            end
         end else begin
            det_run_in = 1'b0;
            if (present_cur) begin
               present_in = 1'b0;
               event_code = EVT_REMOVED;
            end
         end
      end

      rsp_data_in.distance_avg_q8 = avg_ff;
      rsp_data_in.lid_open        = new_open;
      rsp_data_in.lid_changed     = changed;
      rsp_data_in.load_event      = event_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         open_distance_ff <= OpenDistanceReset;
         open_hold_ff     <= OpenHoldReset;
         load_thresh_ff   <= LoadThreshReset;
         detect_hold_ff   <= DetectHoldReset;
         lid_open_ff      <= 1'b0;
         open_run_ff      <= 1'b0;
         open_start_ff    <= 32'd0;
         baseline_ff      <= 24'sd0;
         det_run_ff       <= 1'b0;
         det_start_ff     <= 32'd0;
         present_ff       <= 1'b0;
         last_dist_ff     <= 17'd0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_OPEN_DISTANCE: open_distance_ff <= csr_data[8:0];
               CSR_OPEN_HOLD:     open_hold_ff     <= csr_data[15:0];
               CSR_LOAD_THRESH:   load_thresh_ff   <= csr_data;
               CSR_DETECT_HOLD:   detect_hold_ff   <= csr_data[15:0];
               default:           ;
            endcase
         end
         if (commit) begin
            rsp_valid_ff  <= 1'b1;
            lid_open_ff   <= lid_open_in;
            open_run_ff   <= open_run_in;
            open_start_ff <= open_start_in;
            baseline_ff   <= baseline_in;
            det_run_ff    <= det_run_in;
            det_start_ff  <= det_start_in;
            present_ff    <= present_in;
            last_dist_ff  <= avg_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         req_ff <= req_data;
      end
      if (state_ff == ST_WAIT && avg_status.done) begin
         avg_ff <= avg_status.avg_q8;
      end
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
